[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ptb assertion failed");
`define PTB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ptb assertion failed in reset");
`else
`define PTB_ASSERT(lbl, prop)
`define PTB_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/core/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// Sizes and shared types of the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int MAX_LEN     = 65536;
  localparam int ALPHABET    = 26;
  localparam int NODE_DEPTH  = MAX_LEN + 2;
  localparam int CHILD_DEPTH = NODE_DEPTH * ALPHABET;

  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int NODE_W   = $clog2(NODE_DEPTH);
  localparam int LEN_W    = POS_W + 1;
  localparam int CH_W     = $clog2(ALPHABET);
  localparam int CHILD_AW = $clog2(CHILD_DEPTH);

  localparam int LETTER_W    = 5;
  localparam int OUT_W       = 17;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  localparam int ROOT_EMPTY = 0;
  localparam int ROOT_IMAG  = 1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NODE_W-1:0] fail;
    logic [POS_W-1:0]  cnt;
    logic [NODE_W-1:0] parent;
    logic [CH_W-1:0]   letter;
  } ptb_node_t;

  typedef struct packed {
    logic [OUT_W-1:0] cnt;
    logic [OUT_W-1:0] len;
    logic [OUT_W-1:0] node;
    logic             created;
    logic             full;
  } ptb_res_t;

endpackage

[rtl/core/ptb_core.sv]
// ----------------------------------------------------------------------------
// ptb_core
// Eertree sequencer: fail-link walks, child lookup and node creation over
// text, node and child memories.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptb_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ptb_pkg::CH_W-1:0]    letter_i,
  output logic                        ready_o,
  output logic                        res_valid_o,
  output ptb_pkg::ptb_res_t           res_o,
  input  logic                        res_ready_i
);
  import ptb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WNODE = 3'd1;
  localparam logic [2:0] S_WTEXT = 3'd2;
  localparam logic [2:0] S_WCMP  = 3'd3;
  localparam logic [2:0] S_CREAD = 3'd4;
  localparam logic [2:0] S_CVAL  = 3'd5;
  localparam logic [2:0] S_CNODE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              phase_q, phase_d;
  logic [CH_W-1:0]   c_q, c_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [NODE_W-1:0] p_q, p_d;
  logic [NODE_W-1:0] p1_q, p1_d;
  logic [LEN_W-1:0]  p1len_q, p1len_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [NODE_W-1:0] fail_q, fail_d;
  logic [NODE_W-1:0] vnode_q, vnode_d;
  logic [NODE_W-1:0] last_q, last_d;
  logic [NODE_W-1:0] node_total_q, node_total_d;
  ptb_res_t          res_q, res_d;

  // memories
  logic [CH_W-1:0]   text_mem [MAX_LEN+1];
  ptb_node_t         node_mem [NODE_DEPTH];
  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];

  logic              text_we, text_re;
  logic [POS_W-1:0]  text_wa, text_ra;
  logic [CH_W-1:0]   text_rd_q;
  logic              node_we, node_re;
  logic [NODE_W-1:0] node_wa, node_ra;
  ptb_node_t         node_wd, node_rd_q;
  logic              child_we, child_re, child_sel_p1;
  logic [NODE_W-1:0] child_p;
  logic [CHILD_AW-1:0] child_a;
  logic [NODE_W-1:0] child_wd, child_rd_q;

  logic [LEN_W-1:0]  cur_len, found_len, new_len;
  logic [NODE_W-1:0] cur_fail, new_node, cr_fail;
  logic [POS_W-1:0]  cr_cnt;
  logic signed [LEN_W:0] idx;
  logic              do_create, v_in_range, v_match;

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_wa] <= letter_i;
    end
    if (text_re) begin
      text_rd_q <= text_mem[text_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_a] <= child_wd;
    end
    if (child_re) begin
      child_rd_q <= child_mem[child_a];
    end
  end

  assign child_p = child_sel_p1 ? p1_q : p_q;
  assign child_a = CHILD_AW'(child_p) * CHILD_AW'(ALPHABET) + CHILD_AW'(c_q);

  // roots are constants, other nodes come from memory
  always_comb begin
    if (p_q == NODE_W'(ROOT_EMPTY)) begin
      cur_len  = '0;
      cur_fail = NODE_W'(ROOT_IMAG);
    end else if (p_q == NODE_W'(ROOT_IMAG)) begin
      cur_len  = '1;
      cur_fail = NODE_W'(ROOT_EMPTY);
    end else begin
      cur_len  = node_rd_q.len;
      cur_fail = node_rd_q.fail;
    end
  end

  assign idx = $signed({2'b00, pos_q}) - $signed({cur_len[LEN_W-1], cur_len})
               - (LEN_W+1)'(1);
  assign found_len  = (state_q == S_WTEXT) ? cur_len : plen_q;
  assign new_len    = p1len_q + LEN_W'(2);
  assign new_node   = node_total_q + NODE_W'(1);
  assign v_in_range = (child_rd_q >= NODE_W'(2)) && (child_rd_q <= node_total_q);
  assign v_match    = (node_rd_q.parent == p_q) && (node_rd_q.letter == c_q);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    c_d          = c_q;
    pos_d        = pos_q;
    p_d          = p_q;
    p1_d         = p1_q;
    p1len_d      = p1len_q;
    plen_d       = plen_q;
    fail_d       = fail_q;
    vnode_d      = vnode_q;
    last_d       = last_q;
    node_total_d = node_total_q;
    res_d        = res_q;
    text_we      = 1'b0;
    text_wa      = pos_q + POS_W'(1);
    text_re      = 1'b0;
    text_ra      = idx[POS_W-1:0];
    node_we      = 1'b0;
    node_wa      = new_node;
    node_re      = 1'b0;
    node_ra      = p_q;
    child_we     = 1'b0;
    child_re     = 1'b0;
    child_sel_p1 = 1'b0;
    child_wd     = new_node;
    do_create    = 1'b0;
    cr_fail      = NODE_W'(ROOT_EMPTY);
    cr_cnt       = POS_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (pos_q == POS_W'(MAX_LEN)) begin
            res_d      = '0;
            res_d.full = 1'b1;
            state_d    = S_OUT;
          end else begin
            text_we = 1'b1;
            pos_d   = pos_q + POS_W'(1);
            c_d     = letter_i;
            p_d     = last_q;
            phase_d = 1'b0;
            state_d = S_WNODE;
          end
        end
      end
      S_WNODE: begin
        node_re = (p_q >= NODE_W'(2));
        state_d = S_WTEXT;
      end
      S_WTEXT: begin
        plen_d = cur_len;
        fail_d = cur_fail;
        if (p_q == NODE_W'(ROOT_IMAG)) begin
          if (!phase_q) begin
            p1_d    = p_q;
            p1len_d = found_len;
          end
          state_d = S_CREAD;
        end else if (idx < (LEN_W+1)'(1)) begin
          p_d     = cur_fail;
          state_d = S_WNODE;
        end else begin
          text_re = 1'b1;
          state_d = S_WCMP;
        end
      end
      S_WCMP: begin
        if (text_rd_q == c_q) begin
          if (!phase_q) begin
            p1_d    = p_q;
            p1len_d = found_len;
          end
          state_d = S_CREAD;
        end else begin
          p_d     = fail_q;
          state_d = S_WNODE;
        end
      end
      S_CREAD: begin
        child_re = 1'b1;
        state_d  = S_CVAL;
      end
      S_CVAL: begin
        vnode_d = child_rd_q;
        if (v_in_range) begin
          node_re = 1'b1;
          node_ra = child_rd_q;
          state_d = S_CNODE;
        end else if (phase_q || p_q == NODE_W'(ROOT_IMAG)) begin
          do_create = 1'b1;
        end else begin
          phase_d = 1'b1;
          p_d     = fail_q;
          state_d = S_WNODE;
        end
      end
      S_CNODE: begin
        if (v_match && !phase_q) begin
          res_d.cnt     = OUT_W'(node_rd_q.cnt);
          res_d.len     = OUT_W'(node_rd_q.len);
          res_d.node    = OUT_W'(vnode_q);
          res_d.created = 1'b0;
          res_d.full    = 1'b0;
          last_d        = vnode_q;
          state_d       = S_OUT;
        end else if (v_match) begin
          do_create = 1'b1;
          cr_fail   = vnode_q;
          cr_cnt    = node_rd_q.cnt + POS_W'(1);
        end else if (phase_q || p_q == NODE_W'(ROOT_IMAG)) begin
          do_create = 1'b1;
        end else begin
          phase_d = 1'b1;
          p_d     = fail_q;
          state_d = S_WNODE;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_create) begin
      node_we        = 1'b1;
      node_wd.len    = new_len;
      node_wd.fail   = cr_fail;
      node_wd.cnt    = cr_cnt;
      node_wd.parent = p1_q;
      node_wd.letter = c_q;
      child_we       = 1'b1;
      child_sel_p1   = 1'b1;
      node_total_d   = new_node;
      last_d         = new_node;
      res_d.cnt      = OUT_W'(cr_cnt);
      res_d.len      = OUT_W'(new_len);
      res_d.node     = OUT_W'(new_node);
      res_d.created  = 1'b1;
      res_d.full     = 1'b0;
      state_d        = S_OUT;
    end else begin
      node_wd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= 1'b0;
      pos_q        <= '0;
      last_q       <= NODE_W'(ROOT_IMAG);
      node_total_q <= NODE_W'(ROOT_IMAG);
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      last_q       <= last_d;
      node_total_q <= node_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    p_q     <= p_d;
    p1_q    <= p1_d;
    p1len_q <= p1len_d;
    plen_q  <= plen_d;
    fail_q  <= fail_d;
    vnode_q <= vnode_d;
    res_q   <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  `PTB_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == S_IDLE)
  `PTB_ASSERT(a_pos_bound, pos_q <= POS_W'(MAX_LEN))
  `PTB_ASSERT(a_total_mono, node_total_q >= $past(node_total_q))
  `PTB_ASSERT(a_walk_node, (state_q == S_WTEXT) |-> (p_q <= node_total_q))
  `PTB_ASSERT(a_created_last,
    (state_q == S_OUT && res_q.created) |-> (last_q == node_total_q))

endmodule

[rtl/core/palindromic_tree_builder.sv]
// ----------------------------------------------------------------------------
// palindromic_tree_builder
// Online eertree over a stream of letters, one result word per letter.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one letter per word (0 is a, 25 is z; only the low 5 bits
//   are used, and codes 26 to 31 wrap to 0 to 5). m_axis returns one word
//   per letter: palindromic suffix count, longest palindromic suffix length
//   and its node, plus the created and store-full flags in tuser.
//   s_axis_tready is high only while the sequencer is idle; one letter is
//   worked on at a time. Each letter is written to the text memory; each
//   fail-link walk step then reads the node and the mirrored text letter and
//   compares them. A node whose mirror position lies before the text start
//   skips the text read, and the imaginary root ends the walk. The child
//   lookup reads the child memory and then the candidate node; on a miss the
//   second walk runs, unless the parent is the imaginary root, before the new
//   node and its child link are written. A full store goes straight to the
//   result register. The word passes from there through the output register
//   to m_axis, and the next letter is taken once the core has handed its result to a free output register and is idle.
//   Reset empties the tree at once; no memory clearing pass is needed.
//   When m_axis_tready stays low the finished result is held in the core
//   and the output register, and no new letter is taken until it drains.
// ----------------------------------------------------------------------------
module palindromic_tree_builder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ptb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // letter
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ptb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // suffix_count, longest_length, node_index
  output logic [ptb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // created, full_res
);
  import ptb_pkg::*;

  logic [LETTER_W-1:0] letter_raw, letter_red;
  logic                start, core_ready, res_valid, res_ready;
  ptb_res_t            res;
  logic                m_valid_q;
  ptb_res_t            m_res_q;

  assign letter_raw = s_axis_tdata[LETTER_W-1:0];
  assign letter_red = (letter_raw >= LETTER_W'(ALPHABET))
                      ? letter_raw - LETTER_W'(ALPHABET) : letter_raw;
  assign start      = s_axis_tvalid && core_ready;
  assign res_ready  = !m_valid_q || m_axis_tready;

  ptb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .letter_i    (CH_W'(letter_red)),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign s_axis_tready = core_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 3 * OUT_W)'(0), m_res_q.node, m_res_q.len,
                          m_res_q.cnt};
  assign m_axis_tuser  = {m_res_q.full, m_res_q.created};

endmodule
